[hw/rtl/register_toggle_energy_estimator_top_assert.svh]
// ----------------------------------------------------------------------------
// Register toggle energy estimator: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef REGISTER_TOGGLE_ENERGY_ESTIMATOR_TOP_ASSERT_SVH
`define REGISTER_TOGGLE_ENERGY_ESTIMATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTEE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rtee assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RTEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rtee assertion failed");

`endif

[hw/rtl/rtee_pkg.sv]
// ----------------------------------------------------------------------------
// Register toggle energy estimator package
// Sizes, constants and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package rtee_pkg;

	localparam int NUM_PORTS      = 8;
	localparam int REG_BITS       = 6;
	localparam int CODE_BITS      = 7;
	localparam int FLAGS_PER_PORT = 2 * REG_BITS;
	localparam int VEC_SIZE       = NUM_PORTS * FLAGS_PER_PORT;
	localparam int STORE_DEPTH    = VEC_SIZE + (VEC_SIZE * (VEC_SIZE - 1)) / 2;
	localparam int PORTS_W        = NUM_PORTS * CODE_BITS;
	localparam int COEF_ADDR_W    = $clog2(STORE_DEPTH);
	localparam int IDX_W          = $clog2(VEC_SIZE);
	localparam int COEF_W         = 32;
	localparam int ENERGY_W       = 48;
	localparam int ACC_W          = 50;
	localparam int CFG_INDEX_W    = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_INTERCEPT   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_EMPTY_CODE  = 1'd1;
	localparam logic [CODE_BITS-1:0]   EMPTY_CODE_RST  = 7'd127;

	localparam logic                   MODE_WRITE = 1'b0;
	localparam logic                   MODE_EVAL  = 1'b1;

	localparam logic signed [ENERGY_W-1:0] E_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
	localparam logic signed [ENERGY_W-1:0] E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic wr_coef;
		logic start;
		logic step;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage

`default_nettype wire

[hw/rtl/rtee_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one coefficient write or one evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtee_req_if import rtee_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [PORTS_W-1:0]        prev_ports;
	logic [PORTS_W-1:0]        cur_ports;
	logic [COEF_ADDR_W-1:0]    coef_address;
	logic signed [COEF_W-1:0]  coef_value;

	modport source (output valid, mode, prev_ports, cur_ports, coef_address, coef_value,
		input ready);
	modport sink (input valid, mode, prev_ports, cur_ports, coef_address, coef_value,
		output ready);
endinterface

`default_nettype wire

[hw/rtl/rtee_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one energy estimate.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtee_rsp_if import rtee_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [ENERGY_W-1:0] energy;
	logic                       saturated;

	modport source (output valid, energy, saturated, input ready);
	modport sink (input valid, energy, saturated, output ready);
endinterface

`default_nettype wire

[hw/rtl/register_toggle_energy_estimator_top.sv]
// ----------------------------------------------------------------------------
// Register toggle energy estimator
// Quadratic regression estimate of register-file read-port switching energy.
// ----------------------------------------------------------------------------
// Requests arrive on req: mode 0 stores coef_value at coef_address, mode 1
// evaluates the transition from prev_ports to cur_ports. A write gives no
// response. An evaluation sweeps the whole coefficient memory one entry
// per cycle through its single read port; the sum then passes the drain
// and finish states before it is loaded for rsp, and req is held off during
// the sweep. The response waits in an output register until rsp
// accepts it; a new request is taken meanwhile, but the next evaluation will
// not retire until the previous response has been taken. The configuration
// port writes the intercept (index 0) and the empty port code (index 1) at
// any edge with cfg_we high. Reset sets the intercept to zero and the empty
// code to 127 and leaves the coefficient memory unwritten; every coefficient
// must be written before an evaluation uses it.
// ----------------------------------------------------------------------------
`default_nettype none

module register_toggle_energy_estimator_top import rtee_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [COEF_W-1:0]      cfg_data,
	rtee_req_if.sink                    req,
	rtee_rsp_if.source                  rsp
);

	cmd_t    cmd;
	status_t status;

	rtee_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	rtee_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.prev_ports   (req.prev_ports),
		.cur_ports    (req.cur_ports),
		.coef_address (req.coef_address),
		.coef_value   (req.coef_value),
		.energy       (rsp.energy),
		.saturated    (rsp.saturated)
	);

endmodule

`default_nettype wire

[hw/rtl/rtee_ctrl.sv]
// ----------------------------------------------------------------------------
// Register toggle energy estimator controller
// Sequences coefficient writes, the coefficient sweep and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rtee_ctrl import rtee_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	input  wire logic    req_mode,
	output logic         req_ready,
	output logic         rsp_valid,
	input  wire logic    rsp_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_mode == MODE_EVAL) begin
						cmd.start = 1'b1;
						state_d   = ST_RUN;
					end else begin
						cmd.wr_coef = 1'b1;
					end
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (status.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/rtee_datapath.sv]
// ----------------------------------------------------------------------------
// Register toggle energy estimator datapath
// Toggle flags, coefficient memory, sweep counters, accumulator and result.
// ----------------------------------------------------------------------------
`default_nettype none

module rtee_datapath import rtee_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmd_t                     cmd,
	output status_t                       status,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [COEF_W-1:0]        cfg_data,
	input  wire logic [PORTS_W-1:0]       prev_ports,
	input  wire logic [PORTS_W-1:0]       cur_ports,
	input  wire logic [COEF_ADDR_W-1:0]   coef_address,
	input  wire logic signed [COEF_W-1:0] coef_value,
	output logic signed [ENERGY_W-1:0]    energy,
	output logic                          saturated
);

	logic signed [COEF_W-1:0]   intercept_q;
	logic [CODE_BITS-1:0]       empty_code_q;
	logic [VEC_SIZE-1:0]        flags_d;
	logic [VEC_SIZE-1:0]        flags_q;
	logic signed [COEF_W-1:0]   mem [STORE_DEPTH];
	logic [COEF_ADDR_W-1:0]     addr_q;
	logic [IDX_W-1:0]           i_q;
	logic [IDX_W-1:0]           j_q;
	logic                       single_q;
	logic                       use_term;
	logic signed [COEF_W-1:0]   rdata_s1;
	logic                       use_s1;
	logic                       vld_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ENERGY_W-1:0] energy_q;
	logic                       sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intercept_q  <= '0;
			empty_code_q <= EMPTY_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INTERCEPT:  intercept_q  <= cfg_data;
				CFG_EMPTY_CODE: empty_code_q <= cfg_data[CODE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		logic [CODE_BITS-1:0] pv;
		logic [CODE_BITS-1:0] cv;
		flags_d = '0;
		for (int p = 0; p < NUM_PORTS; p++) begin
			pv = prev_ports[p*CODE_BITS +: CODE_BITS];
			cv = cur_ports[p*CODE_BITS +: CODE_BITS];
			if (pv != empty_code_q && cv != empty_code_q) begin
				for (int k = 0; k < REG_BITS; k++) begin
					flags_d[p*FLAGS_PER_PORT + k] =
						pv[REG_BITS-1-k] & ~cv[REG_BITS-1-k];
					flags_d[p*FLAGS_PER_PORT + REG_BITS + k] =
						~pv[REG_BITS-1-k] & cv[REG_BITS-1-k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_coef && coef_address < COEF_ADDR_W'(STORE_DEPTH)) begin
			mem[coef_address] <= coef_value;
		end
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[addr_q];
		use_s1   <= use_term;
	end

	assign use_term    = single_q ? flags_q[i_q] : (flags_q[i_q] & flags_q[j_q]);
	assign status.last = !single_q && i_q == IDX_W'(VEC_SIZE - 2)
		&& j_q == IDX_W'(VEC_SIZE - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			i_q      <= '0;
			j_q      <= '0;
			single_q <= 1'b1;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= cmd.step;
			if (cmd.start) begin
				addr_q   <= '0;
				i_q      <= '0;
				j_q      <= '0;
				single_q <= 1'b1;
			end else if (cmd.step) begin
				addr_q <= addr_q + 1'b1;
				if (single_q) begin
					if (i_q == IDX_W'(VEC_SIZE - 1)) begin
						single_q <= 1'b0;
						i_q      <= '0;
						j_q      <= IDX_W'(1);
					end else begin
						i_q <= i_q + 1'b1;
					end
				end else if (j_q == IDX_W'(VEC_SIZE - 1)) begin
					i_q <= i_q + 1'b1;
					j_q <= i_q + IDX_W'(2);
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			flags_q <= flags_d;
			acc_q   <= ACC_W'(intercept_q);
		end else if (vld_s1 && use_s1) begin
			acc_q <= acc_q + ACC_W'(rdata_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (acc_q > ACC_W'(E_MAX)) begin
				energy_q <= E_MAX;
				sat_q    <= 1'b1;
			end else if (acc_q < ACC_W'(E_MIN)) begin
				energy_q <= E_MIN;
				sat_q    <= 1'b1;
			end else begin
				energy_q <= acc_q[ENERGY_W-1:0];
				sat_q    <= 1'b0;
			end
		end
	end

	assign energy    = energy_q;
	assign saturated = sat_q;

endmodule

`default_nettype wire

[hw/rtl/rtee_checker.sv]
// ----------------------------------------------------------------------------
// Register toggle energy estimator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "register_toggle_energy_estimator_top_assert.svh"

module rtee_checker import rtee_pkg::*; (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic                       req_mode,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic signed [ENERGY_W-1:0] rsp_energy,
	input wire logic                       rsp_saturated
);

	`RTEE_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_energy))
	`RTEE_ASSERT_SAME(a_sat_clip, clk, arst_n, rsp_valid && rsp_saturated, rsp_energy == E_MAX || rsp_energy == E_MIN)
	`RTEE_ASSERT_NEXT(a_eval_busy, clk, arst_n, req_valid && req_ready && req_mode == MODE_EVAL, !req_ready)
	`RTEE_ASSERT_NEXT(a_write_fast, clk, arst_n, req_valid && req_ready && req_mode == MODE_WRITE, req_ready)

endmodule

bind register_toggle_energy_estimator_top rtee_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_mode      (req.mode),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_energy    (rsp.energy),
	.rsp_saturated (rsp.saturated)
);

`default_nettype wire
